/* design/msd_pkg.sv */
// Shared types and constants for the mean and standard deviation block.
`timescale 1ns / 1ps
package msd_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int SD_W            = 16;
   localparam int SQRT_STEPS      = 16;
   localparam int MAX_SAMPLES_DEF = 512;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mean_value;
      logic        [SD_W-1:0]     std_deviation;
      logic                       overflow;
   } rsp_type;

endpackage

/* design/msd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module msd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/msd_div.sv */
// Restoring unsigned divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps
module msd_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [NUM_W-1:0]  quo_ff;
   logic [NUM_W-1:0]  quo_in;
   logic [DEN_W-1:0]  rem_ff;
   logic [DEN_W-1:0]  rem_in;
   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W:0]    rem_shift;
   logic [DEN_W:0]    rem_diff;
   logic              fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[NUM_W-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
      fits      = !rem_diff[DEN_W];
      rem_in    = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
      quo_in    = {quo_ff[NUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == STEP_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         step_ff <= STEP_W'(NUM_W);
         quo_ff  <= numer;
         rem_ff  <= '0;
         den_ff  <= denom;
      end else if (busy_ff) begin
         step_ff <= step_ff - STEP_W'(1);
         quo_ff  <= quo_in;
         rem_ff  <= rem_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

/* design/mean_and_std_deviation_top.sv */
// A set of N samples loads at one word per cycle, but only while the block waits in its
// load state; no new sample is taken while a set is being reduced. The result comes from
// a read pass over the sample memory and a bit-serial divider, run once for the mean and
// once for the variance, and then a bit-serial square root; the next set may load while
// the result word waits.
// Reset clears the control state; the sample memory is never read past the current set.
`timescale 1ns / 1ps
module mean_and_std_deviation_top
   import msd_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int SUM_W  = SAMPLE_W + CNT_W;
   localparam int SQ_W   = 2 * SAMPLE_W;
   localparam int ACC_W  = SQ_W + CNT_W;
   localparam int STEP_W = $clog2(SQRT_STEPS);

   typedef enum logic [7:0] {
      ST_LOAD      = 8'b0000_0001,
      ST_MEAN_GO   = 8'b0000_0010,
      ST_MEAN_WAIT = 8'b0000_0100,
      ST_PASS      = 8'b0000_1000,
      ST_VAR_GO    = 8'b0001_0000,
      ST_VAR_WAIT  = 8'b0010_0000,
      ST_SQRT      = 8'b0100_0000,
      ST_OUT       = 8'b1000_0000
   } state_type;

   state_type                  state_ff;
   state_type                  state_in;
   logic [CNT_W-1:0]           count_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic                       overflow_ff;
   logic signed [SAMPLE_W-1:0] mean_ff;
   logic [CNT_W-1:0]           iss_ff;
   logic                       pv1_ff;
   logic                       pv2_ff;
   logic                       pv3_ff;
   logic [SAMPLE_W-1:0]        abs_ff;
   logic [SQ_W-1:0]            sq_ff;
   logic [ACC_W-1:0]           acc_ff;
   logic [SQ_W-1:0]            rad_ff;
   logic [SD_W:0]              rem_ff;
   logic [SD_W-1:0]            root_ff;
   logic [STEP_W-1:0]          step_ff;
   rsp_type                    rsp_ff;
   logic                       rsp_valid_ff;

   logic                       req_go;
   logic                       has_room;
   logic                       issue;
   logic                       pass_empty;
   logic                       out_go;
   logic                       div_start;
   logic                       div_done;
   logic [ACC_W-1:0]           div_numer;
   logic [ACC_W-1:0]           div_quot;
   logic [SUM_W-1:0]           sum_mag;
   logic [SAMPLE_W-1:0]        mean_mag;
   logic [SAMPLE_W-1:0]        ram_rdata;
   logic signed [SAMPLE_W:0]   diff;
   logic [SAMPLE_W:0]          diff_mag;
   logic [SD_W+1:0]            rem_shift;
   logic [SD_W+1:0]            rem_trial;
   logic [SD_W+1:0]            rem_diff;

   assign req_ready  = (state_ff == ST_LOAD);
   assign req_go     = req_valid && req_ready;
   assign has_room   = (count_ff != CNT_W'(MAX_SAMPLES));
   assign issue      = (state_ff == ST_PASS) && (iss_ff != count_ff);
   assign pass_empty = (iss_ff == count_ff) && !pv1_ff && !pv2_ff && !pv3_ff;
   assign out_go     = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign div_start  = (state_ff == ST_MEAN_GO) || (state_ff == ST_VAR_GO);

   always_comb begin
      sum_mag   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      div_numer = (state_ff == ST_MEAN_GO) ? ACC_W'(sum_mag) : acc_ff;
      mean_mag  = sum_ff[SUM_W-1] ? SAMPLE_W'(-div_quot[SAMPLE_W-1:0])
                                  : div_quot[SAMPLE_W-1:0];
      diff      = $signed({ram_rdata[SAMPLE_W-1], ram_rdata})
                  - $signed({mean_ff[SAMPLE_W-1], mean_ff});
      diff_mag  = diff[SAMPLE_W] ? (SAMPLE_W + 1)'(-diff) : (SAMPLE_W + 1)'(diff);
      rem_shift = {rem_ff[SD_W-1:0], rad_ff[SQ_W-1 -: 2]};
      rem_trial = {root_ff, 2'b01};
      rem_diff  = rem_shift - rem_trial;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_go && req_data.last_sample) begin
               state_in = ST_MEAN_GO;
            end
         end
         ST_MEAN_GO: begin
            state_in = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_done) begin
               state_in = ST_PASS;
            end
         end
         ST_PASS: begin
            if (pass_empty) begin
               state_in = ST_VAR_GO;
            end
         end
         ST_VAR_GO: begin
            state_in = ST_VAR_WAIT;
         end
         ST_VAR_WAIT: begin
            if (div_done) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (step_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_go) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         sum_ff       <= '0;
         overflow_ff  <= 1'b0;
         pv1_ff       <= 1'b0;
         pv2_ff       <= 1'b0;
         pv3_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv1_ff   <= issue;
         pv2_ff   <= pv1_ff;
         pv3_ff   <= pv2_ff;
         if (req_go) begin
            if (has_room) begin
               count_ff <= count_ff + CNT_W'(1);
               sum_ff   <= sum_ff + SUM_W'(req_data.sample);
            end else begin
               overflow_ff <= 1'b1;
            end
         end else if (out_go) begin
            count_ff    <= '0;
            sum_ff      <= '0;
            overflow_ff <= 1'b0;
         end
         if (out_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MEAN_WAIT && div_done) begin
         mean_ff <= mean_mag;
         iss_ff  <= '0;
         acc_ff  <= '0;
      end else begin
         if (issue) begin
            iss_ff <= iss_ff + CNT_W'(1);
         end
         if (pv3_ff) begin
            acc_ff <= acc_ff + ACC_W'(sq_ff);
         end
      end
      abs_ff <= diff_mag[SAMPLE_W-1:0];
      sq_ff  <= abs_ff * abs_ff;
      if (state_ff == ST_VAR_WAIT && div_done) begin
         rad_ff  <= div_quot[SQ_W-1:0];
         rem_ff  <= '0;
         root_ff <= '0;
         step_ff <= STEP_W'(SQRT_STEPS - 1);
      end else if (state_ff == ST_SQRT) begin
         rad_ff  <= {rad_ff[SQ_W-3:0], 2'b00};
         step_ff <= step_ff - STEP_W'(1);
         if (!rem_diff[SD_W+1]) begin
            rem_ff  <= rem_diff[SD_W:0];
            root_ff <= {root_ff[SD_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift[SD_W:0];
            root_ff <= {root_ff[SD_W-2:0], 1'b0};
         end
      end
      if (out_go) begin
         rsp_ff.mean_value    <= mean_ff;
         rsp_ff.std_deviation <= root_ff;
         rsp_ff.overflow      <= overflow_ff;
      end
   end

   msd_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_go && has_room),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_data.sample),
      .rd_en   (issue),
      .rd_addr (iss_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   msd_div #(
      .NUM_W (ACC_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (count_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count exceeds the store depth");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result word raised outside the output state");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      out_go |=> (count_ff == '0 && !overflow_ff))
      else $error("set state not cleared after a result word");

   a_pass_idle_in_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !(pv1_ff || pv2_ff || pv3_ff))
      else $error("read pass still active while loading samples");
`endif

endmodule

/* bench/tb_mean_and_std_deviation_top.sv */
// Self-checking testbench for the mean and standard deviation block.
`timescale 1ns / 1ps
module tb_mean_and_std_deviation_top;
   import msd_pkg::*;

   localparam int STORE_DEPTH  = MAX_SAMPLES_DEF;
   localparam int TARGET_WORDS = 1450;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 200;
   localparam int MAX_REPORTS  = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_words[$];
   rsp_type expected_stats[$];
   int      total_words;
   int      mismatch_count = 0;
   int      result_count   = 0;
   int      cycle_count    = 0;
   int      burst_left;
   int      gap_left;
   logic [7:0] stall_phase;

   logic signed [SAMPLE_W-1:0] sample_mem [STORE_DEPTH];
   int                         set_count   = 0;
   longint                     set_sum     = 0;
   bit                         set_dropped = 1'b0;

   mean_and_std_deviation_top #(
      .MAX_SAMPLES(STORE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [SD_W-1:0] floor_sqrt(input longint unsigned radicand);
      longint unsigned guess;
      longint unsigned trial;
      guess = 0;
      for (int b = 20; b >= 0; b--) begin
         trial = guess | (64'd1 << b);
         if (trial * trial <= radicand) begin
            guess = trial;
         end
      end
      return guess[SD_W-1:0];
   endfunction

   task automatic absorb_sample(input req_type w);
      longint          mean;
      longint          diff;
      longint unsigned sq_total;
      rsp_type         outcome;
      if (set_count < STORE_DEPTH) begin
         sample_mem[set_count] = w.sample;
         set_count++;
         set_sum += $signed(w.sample);
      end else begin
         set_dropped = 1'b1;
      end
      if (w.last_sample) begin
         mean     = 0;
         sq_total = 0;
         outcome  = '0;
         if (set_count != 0) begin
            mean = set_sum / set_count;
            for (int i = 0; i < set_count; i++) begin
               diff = $signed(sample_mem[i]) - mean;
               sq_total += longint'(diff * diff);
            end
            outcome.std_deviation = floor_sqrt(sq_total / longint'(set_count));
         end
         outcome.mean_value = mean[SAMPLE_W-1:0];
         outcome.overflow   = set_dropped;
         expected_stats.push_back(outcome);
         set_count   = 0;
         set_sum     = 0;
         set_dropped = 1'b0;
      end
   endtask

   task automatic push_word(input logic [SAMPLE_W-1:0] value, input bit last);
      req_type w;
      w.sample      = value;
      w.last_sample = last;
      pending_words.push_back(w);
      total_words++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample(input int mode,
                                                       input logic [SAMPLE_W-1:0] base);
      logic [SAMPLE_W-1:0] value;
      case (mode)
         1: value = base + SAMPLE_W'($urandom_range(0, 255));
         2: begin
            case ($urandom_range(0, 4))
               0: value = 16'h7FFF;
               1: value = 16'h8000;
               2: value = 16'h0000;
               3: value = 16'hFFFF;
               default: value = SAMPLE_W'($urandom_range(0, 65535));
            endcase
         end
         default: value = SAMPLE_W'($urandom_range(0, 65535));
      endcase
      return value;
   endfunction

   task automatic add_set(input int len);
      int                  mode;
      logic [SAMPLE_W-1:0] base;
      mode = $urandom_range(0, 2);
      base = SAMPLE_W'($urandom_range(0, 65535));
      for (int i = 0; i < len; i++) begin
         push_word(pick_sample(mode, base), i == len - 1);
      end
   endtask

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%s", what);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         req_data   <= '0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_words.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 48);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_phase <= '0;
      end else begin
         stall_phase <= stall_phase + 1'b1;
         case (stall_phase[7:6])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= 1'($urandom_range(0, 1));
            2'd2: rsp_ready <= ($urandom_range(0, 7) == 0);
            default: rsp_ready <= stall_phase[2];
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (expected_stats.size() == 0) begin
               flag_mismatch($sformatf(
                  "result %0d arrived with none expected: mean %0d sd %0d ovf %0b",
                  result_count, $signed(rsp_data.mean_value), rsp_data.std_deviation,
                  rsp_data.overflow));
            end else begin
               want = expected_stats.pop_front();
               if (rsp_data.mean_value !== want.mean_value
                   || rsp_data.std_deviation !== want.std_deviation
                   || rsp_data.overflow !== want.overflow) begin
                  flag_mismatch($sformatf(
                     "result %0d: expected mean %0d sd %0d ovf %0b, got mean %0d sd %0d ovf %0b",
                     result_count, $signed(want.mean_value), want.std_deviation, want.overflow,
                     $signed(rsp_data.mean_value), rsp_data.std_deviation, rsp_data.overflow));
               end
            end
         end
         if (req_valid && req_ready) begin
            absorb_sample(req_data);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("mean_and_std_deviation_top: mismatch");
         $finish;
      end
   end

   initial begin
      int  roll;
      bit  full_set_done;
      bit  drop_set_done;
      total_words    = 0;
      full_set_done  = 1'b0;
      drop_set_done  = 1'b0;

      push_word(16'h0000, 1'b1);
      push_word(16'h7FFF, 1'b1);
      push_word(16'h8000, 1'b1);
      push_word(16'h7FFF, 1'b0);
      push_word(16'h8000, 1'b1);
      push_word(16'h8000, 1'b0);
      push_word(16'h8000, 1'b0);
      push_word(16'h8001, 1'b1);
      push_word(16'hFFFD, 1'b0);
      push_word(16'hFFFE, 1'b1);
      push_word(16'h0100, 1'b0);
      push_word(16'hFF00, 1'b0);
      push_word(16'h0001, 1'b0);
      push_word(16'hFFFF, 1'b1);
      push_word(16'h7FFF, 1'b0);
      push_word(16'h7FFF, 1'b0);
      push_word(16'h7FFF, 1'b1);
      push_word(16'h5555, 1'b0);
      push_word(16'hAAAA, 1'b1);

      while (total_words < TARGET_WORDS) begin
         if (!full_set_done && total_words >= 300) begin
            add_set(STORE_DEPTH);
            full_set_done = 1'b1;
         end else if (!drop_set_done && total_words >= 900) begin
            add_set(STORE_DEPTH + 8);
            drop_set_done = 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               add_set($urandom_range(1, 6));
            end else if (roll < 95) begin
               add_set($urandom_range(7, 24));
            end else begin
               add_set($urandom_range(25, 64));
            end
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (pending_words.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      while (expected_stats.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("mean_and_std_deviation_top: match");
      end else begin
         $display("mean_and_std_deviation_top: mismatch");
      end
      $finish;
   end

endmodule

/* sim.f */
design/msd_pkg.sv
design/msd_ram.sv
design/msd_div.sv
design/mean_and_std_deviation_top.sv
bench/tb_mean_and_std_deviation_top.sv
